### design/msched_pkg.sv
// ----------------------------------------------------------------------------
// msched_pkg
// Shared codes for the multilevel ready-queue scheduler: event kinds, task
// status codes and register layout.
// ----------------------------------------------------------------------------
package msched_pkg;

  localparam int KIND_W = 3;
  localparam int STAT_W = 3;
  localparam int THR_W  = 16;
  localparam int TICK_W = 32;
  localparam int ADDR_W = 3;

  localparam logic [KIND_W-1:0] K_ADD    = 3'd0;
  localparam logic [KIND_W-1:0] K_REMOVE = 3'd1;
  localparam logic [KIND_W-1:0] K_SLEEP  = 3'd2;
  localparam logic [KIND_W-1:0] K_EXIT   = 3'd3;
  localparam logic [KIND_W-1:0] K_TICK   = 3'd4;

  localparam logic [STAT_W-1:0] ST_UNUSED   = 3'd0;
  localparam logic [STAT_W-1:0] ST_READY    = 3'd1;
  localparam logic [STAT_W-1:0] ST_RUNNING  = 3'd2;
  localparam logic [STAT_W-1:0] ST_SLEEPING = 3'd3;
  localparam logic [STAT_W-1:0] ST_EXITED   = 3'd4;

  localparam logic [ADDR_W-1:0] REG_AGING_THR = 3'd0;
  localparam logic [THR_W-1:0]  AGING_THR_RST = 16'd100;

endpackage

### design/msched_regs.sv
// ----------------------------------------------------------------------------
// msched_regs
// APB register block holding the aging threshold.
// ----------------------------------------------------------------------------
module msched_regs
  import msched_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output logic [THR_W-1:0]  aging_thr
);

  logic [THR_W-1:0] thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= AGING_THR_RST;
    end else if (psel && penable && pwrite && paddr == REG_AGING_THR) begin
      thr_r <= pwdata[THR_W-1:0];
    end
  end

  assign pready    = 1'b1;
  assign prdata    = (paddr == REG_AGING_THR) ? {{(32-THR_W){1'b0}}, thr_r} : 32'd0;
  assign aging_thr = thr_r;

endmodule

### design/multilevel_ready_queue_scheduler.sv
// ----------------------------------------------------------------------------
// multilevel_ready_queue_scheduler
// Task scheduler with one FIFO ready queue per priority level and aging.
// Add/remove/sleep/exit words are applied in the event state after accept;
// unknown kinds are dropped; a tick runs wakeup, aging, requeue of the running
// task and the pick: one slot per cycle through the shared compare unit for
// wakeup, then aging, then one level per cycle for the pick, which waits while
// an earlier result word is still unaccepted. One word is in work at a time.
// Synchronous active-low reset: all tasks unused, queues empty, tick zero.
// ----------------------------------------------------------------------------
module multilevel_ready_queue_scheduler
  import msched_pkg::*;
#(
  parameter int TASK_SLOTS      = 16,
  parameter int PRIORITY_LEVELS = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [2:0]        in_kind,
  input  logic [3:0]        in_task_id,
  input  logic [7:0]        in_base_priority,
  input  logic [31:0]       in_wake_at,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [3:0]        out_chosen_task,
  output logic              out_status,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int IW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int CW = $clog2(TASK_SLOTS + 1);
  localparam int LW = $clog2(PRIORITY_LEVELS);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EVT  = 3'd1;
  localparam logic [2:0] S_WAKE = 3'd2;
  localparam logic [2:0] S_AGE  = 3'd3;
  localparam logic [2:0] S_REQ  = 3'd4;
  localparam logic [2:0] S_PICK = 3'd5;

  logic [THR_W-1:0] aging_thr;

  msched_regs u_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .aging_thr(aging_thr)
  );

  // task table; queue order kept as a position within the level
  logic [STAT_W-1:0] status_r [TASK_SLOTS];
  logic [STAT_W-1:0] status_nxt [TASK_SLOTS];
  logic [LW-1:0]     base_r [TASK_SLOTS];
  logic [LW-1:0]     base_nxt [TASK_SLOTS];
  logic [LW-1:0]     eff_r [TASK_SLOTS];
  logic [LW-1:0]     eff_nxt [TASK_SLOTS];
  logic [TICK_W-1:0] since_r [TASK_SLOTS];
  logic [TICK_W-1:0] since_nxt [TASK_SLOTS];
  logic [TICK_W-1:0] wake_r [TASK_SLOTS];
  logic [TICK_W-1:0] wake_nxt [TASK_SLOTS];
  logic              linked_r [TASK_SLOTS];
  logic              linked_nxt [TASK_SLOTS];
  logic [IW-1:0]     pos_r [TASK_SLOTS];
  logic [IW-1:0]     pos_nxt [TASK_SLOTS];
  logic [CW-1:0]     cnt_r [PRIORITY_LEVELS];
  logic [CW-1:0]     cnt_nxt [PRIORITY_LEVELS];

  logic [2:0]        state_r, state_nxt;
  logic [IW-1:0]     idx_r, idx_nxt;
  logic [LW-1:0]     lvl_r, lvl_nxt;
  logic [TICK_W-1:0] tick_r, tick_nxt;
  logic [IW-1:0]     run_r, run_nxt;
  logic              run_vld_r, run_vld_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [3:0]        out_task_r, out_task_nxt;
  logic              out_stat_r, out_stat_nxt;

  logic [KIND_W-1:0] kind_r;
  logic [IW-1:0]     id_r;
  logic [7:0]        prio_r;
  logic [TICK_W-1:0] wake_at_r;

  logic              accept;
  logic [IW-1:0]     c;
  logic              do_unl, do_psh;
  logic [LW-1:0]     psh_lvl;
  logic [LW-1:0]     add_lvl;
  logic              head_found;
  logic [IW-1:0]     head_idx;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  assign add_lvl = (prio_r >= 8'(PRIORITY_LEVELS)) ? LW'(PRIORITY_LEVELS - 1)
                                                   : prio_r[LW-1:0];

  // front of the current level: linked, on this level, position zero
  always_comb begin
    head_found = 1'b0;
    head_idx   = '0;
    for (int j = 0; j < TASK_SLOTS; j++) begin
      if (!head_found && linked_r[j] && eff_r[j] == lvl_r && pos_r[j] == '0) begin
        head_found = 1'b1;
        head_idx   = IW'(j);
      end
    end
  end

  always_comb begin
    status_nxt    = status_r;
    base_nxt      = base_r;
    eff_nxt       = eff_r;
    since_nxt     = since_r;
    wake_nxt      = wake_r;
    linked_nxt    = linked_r;
    pos_nxt       = pos_r;
    cnt_nxt       = cnt_r;
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    lvl_nxt       = lvl_r;
    tick_nxt      = tick_r;
    run_nxt       = run_r;
    run_vld_nxt   = run_vld_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_task_nxt  = out_task_r;
    out_stat_nxt  = out_stat_r;
    c             = idx_r;
    do_unl        = 1'b0;
    do_psh        = 1'b0;
    psh_lvl       = '0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_kind == K_TICK) begin
            tick_nxt  = tick_r + 32'd1;
            idx_nxt   = '0;
            state_nxt = S_WAKE;
          end else if (in_kind < K_TICK && 32'(in_task_id) < TASK_SLOTS) begin
            state_nxt = S_EVT;
          end
        end
      end
      S_EVT: begin
        c         = id_r;
        state_nxt = S_IDLE;
        unique case (kind_r)
          K_ADD: begin
            if (status_r[c] != ST_UNUSED && status_r[c] != ST_EXITED) begin
              do_unl        = 1'b1;
              do_psh        = 1'b1;
              psh_lvl       = add_lvl;
              status_nxt[c] = ST_READY;
              base_nxt[c]   = add_lvl;
              since_nxt[c]  = tick_r;
            end
          end
          K_REMOVE: begin
            do_unl = 1'b1;
          end
          K_SLEEP: begin
            do_unl        = 1'b1;
            wake_nxt[c]   = wake_at_r;
            status_nxt[c] = ST_SLEEPING;
          end
          default: begin
            do_unl        = 1'b1;
            status_nxt[c] = ST_EXITED;
          end
        endcase
      end
      S_WAKE: begin
        if (status_r[c] == ST_SLEEPING && tick_r >= wake_r[c]) begin
          do_unl        = 1'b1;
          do_psh        = 1'b1;
          psh_lvl       = base_r[c];
          status_nxt[c] = ST_READY;
          since_nxt[c]  = tick_r;
        end
        idx_nxt = idx_r + IW'(1);
        if (idx_r == IW'(TASK_SLOTS - 1)) begin
          idx_nxt   = '0;
          state_nxt = S_AGE;
        end
      end
      S_AGE: begin
        if (status_r[c] == ST_READY && eff_r[c] != '0 &&
            (tick_r - since_r[c]) >= 32'(aging_thr)) begin
          do_unl       = 1'b1;
          do_psh       = 1'b1;
          psh_lvl      = eff_r[c] - LW'(1);
          since_nxt[c] = tick_r;
        end
        idx_nxt = idx_r + IW'(1);
        if (idx_r == IW'(TASK_SLOTS - 1)) begin
          state_nxt = S_REQ;
        end
      end
      S_REQ: begin
        c = run_r;
        if (run_vld_r && status_r[c] == ST_RUNNING) begin
          do_unl        = 1'b1;
          do_psh        = 1'b1;
          psh_lvl       = base_r[c];
          status_nxt[c] = ST_READY;
          since_nxt[c]  = tick_r;
        end
        lvl_nxt   = '0;
        state_nxt = S_PICK;
      end
      S_PICK: begin
        c = head_idx;
        if (out_valid_r && !out_ready) begin
          // earlier result word still waiting at the output
          state_nxt = S_PICK;
        end else if (head_found) begin
          do_unl        = 1'b1;
          status_nxt[c] = ST_RUNNING;
          run_nxt       = c;
          run_vld_nxt   = 1'b1;
          out_valid_nxt = 1'b1;
          out_task_nxt  = 4'(c);
          out_stat_nxt  = 1'b0;
          state_nxt     = S_IDLE;
        end else if (lvl_r == LW'(PRIORITY_LEVELS - 1)) begin
          run_vld_nxt   = 1'b0;
          out_valid_nxt = 1'b1;
          out_task_nxt  = 4'd0;
          out_stat_nxt  = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          lvl_nxt = lvl_r + LW'(1);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // unlink closes the gap behind the task, push appends at the back
    if (do_unl && linked_r[c]) begin
      for (int j = 0; j < TASK_SLOTS; j++) begin
        if (linked_r[j] && eff_r[j] == eff_r[c] && pos_r[j] > pos_r[c]) begin
          pos_nxt[j] = pos_r[j] - IW'(1);
        end
      end
      cnt_nxt[eff_r[c]] = cnt_r[eff_r[c]] - CW'(1);
      linked_nxt[c]     = 1'b0;
    end
    if (do_psh) begin
      pos_nxt[c]       = IW'(cnt_nxt[psh_lvl]);
      cnt_nxt[psh_lvl] = cnt_nxt[psh_lvl] + CW'(1);
      linked_nxt[c]    = 1'b1;
      eff_nxt[c]       = psh_lvl;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      lvl_r       <= '0;
      tick_r      <= '0;
      run_r       <= '0;
      run_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
      for (int j = 0; j < TASK_SLOTS; j++) begin
        status_r[j] <= ST_UNUSED;
        base_r[j]   <= '0;
        eff_r[j]    <= '0;
        linked_r[j] <= 1'b0;
      end
      for (int l = 0; l < PRIORITY_LEVELS; l++) begin
        cnt_r[l] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      lvl_r       <= lvl_nxt;
      tick_r      <= tick_nxt;
      run_r       <= run_nxt;
      run_vld_r   <= run_vld_nxt;
      out_valid_r <= out_valid_nxt;
      status_r    <= status_nxt;
      base_r      <= base_nxt;
      eff_r       <= eff_nxt;
      linked_r    <= linked_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    since_r    <= since_nxt;
    wake_r     <= wake_nxt;
    pos_r      <= pos_nxt;
    out_task_r <= out_task_nxt;
    out_stat_r <= out_stat_nxt;
    if (accept) begin
      kind_r    <= in_kind;
      id_r      <= IW'(in_task_id);
      prio_r    <= in_base_priority;
      wake_at_r <= in_wake_at;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_chosen_task = out_task_r;
  assign out_status      = out_stat_r;

endmodule

### tb/tb_multilevel_ready_queue_scheduler.sv
// ----------------------------------------------------------------------------
// tb_multilevel_ready_queue_scheduler
// Drives add, remove, sleep, exit, tick and unknown-kind words into the
// scheduler under several aging thresholds. A scoreboard keeps its own copy of the task
// table and ready queues and checks every chosen task against it.
// ----------------------------------------------------------------------------
module tb_multilevel_ready_queue_scheduler;
  import msched_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS  = 16;
  localparam int LEVELS = 4;
  localparam int NONE   = SLOTS;
  localparam logic [KIND_W-1:0] K_UNKNOWN_FIRST = 3'd5;
  localparam logic [KIND_W-1:0] K_UNKNOWN_LAST  = 3'd7;

  typedef struct packed {
    logic [3:0] chosen;
    logic       idle;
  } pick_t;

  class sched_scoreboard;
    logic [STAT_W-1:0] status [SLOTS];
    logic [1:0]        base_lvl [SLOTS];
    logic [1:0]        eff_lvl [SLOTS];
    logic [31:0]       since [SLOTS];
    logic [31:0]       wake [SLOTS];
    int                nxt [SLOTS];
    int                prv [SLOTS];
    bit                queued [SLOTS];
    int                head [LEVELS];
    int                tail [LEVELS];
    int                running;
    logic [31:0]       ticks;
    logic [THR_W-1:0]  thr;
    pick_t             picks[$];
    int                errors;

    function void clear();
      for (int i = 0; i < SLOTS; i++) begin
        status[i] = ST_UNUSED; base_lvl[i] = 0; eff_lvl[i] = 0;
        since[i] = 0; wake[i] = 0; nxt[i] = NONE; prv[i] = NONE; queued[i] = 0;
      end
      for (int l = 0; l < LEVELS; l++) begin
        head[l] = NONE; tail[l] = NONE;
      end
      running = NONE;
      ticks = 0;
      thr = AGING_THR_RST;
      errors = 0;
    endfunction

    function void unlink(int t);
      int p;
      int n;
      if (!queued[t]) return;
      p = prv[t];
      n = nxt[t];
      if (p == NONE) head[eff_lvl[t]] = n; else nxt[p] = n;
      if (n == NONE) tail[eff_lvl[t]] = p; else prv[n] = p;
      nxt[t] = NONE; prv[t] = NONE; queued[t] = 0;
    endfunction

    function void enqueue(int t, int lvl);
      int tl;
      tl = tail[lvl];
      prv[t] = tl;
      nxt[t] = NONE;
      if (tl == NONE) head[lvl] = t; else nxt[tl] = t;
      tail[lvl] = t;
      queued[t] = 1;
    endfunction

    function void make_ready(int t, logic [7:0] prio);
      logic [1:0] lvl;
      if (status[t] == ST_UNUSED || status[t] == ST_EXITED) return;
      unlink(t);
      status[t] = ST_READY;
      lvl = (prio >= LEVELS) ? 2'(LEVELS - 1) : prio[1:0];
      base_lvl[t] = lvl;
      eff_lvl[t] = lvl;
      since[t] = ticks;
      enqueue(t, lvl);
    endfunction

    function pick_t run_tick();
      pick_t r;
      ticks = ticks + 1;
      for (int i = 0; i < SLOTS; i++)
        if (status[i] == ST_SLEEPING && ticks >= wake[i]) make_ready(i, 8'(base_lvl[i]));
      for (int i = 0; i < SLOTS; i++) begin
        if (status[i] != ST_READY || eff_lvl[i] == 0) continue;
        if (32'(ticks - since[i]) < {16'd0, thr}) continue;
        unlink(i);
        eff_lvl[i] = eff_lvl[i] - 1;
        since[i] = ticks;
        enqueue(i, eff_lvl[i]);
      end
      if (running != NONE && status[running] == ST_RUNNING)
        make_ready(running, 8'(base_lvl[running]));
      for (int l = 0; l < LEVELS; l++) begin
        if (head[l] == NONE) continue;
        r.chosen = 4'(head[l]);
        r.idle = 0;
        unlink(head[l]);
        status[r.chosen] = ST_RUNNING;
        running = r.chosen;
        return r;
      end
      running = NONE;
      r.chosen = 0;
      r.idle = 1;
      return r;
    endfunction

    function void note(logic [2:0] kind, logic [3:0] id, logic [7:0] prio, logic [31:0] wk);
      case (kind)
        K_TICK: picks.push_back(run_tick());
        K_ADD: make_ready(id, prio);
        K_REMOVE: unlink(id);
        K_SLEEP: begin
          unlink(id);
          wake[id] = wk;
          status[id] = ST_SLEEPING;
        end
        K_EXIT: begin
          status[id] = ST_EXITED;
          unlink(id);
        end
        default: ;
      endcase
    endfunction

    function void check(logic [3:0] chosen, logic idle);
      pick_t e;
      if (picks.size() == 0) begin
        $error("unexpected word: chosen_task %0d status %0d", chosen, idle);
        errors++;
        return;
      end
      e = picks.pop_front();
      if (chosen !== e.chosen) begin
        $error("chosen_task: expected %0d, actual %0d", e.chosen, chosen);
        errors++;
      end
      if (idle !== e.idle) begin
        $error("status: expected %0d, actual %0d", e.idle, idle);
        errors++;
      end
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [2:0]        in_kind;
  logic [3:0]        in_task_id;
  logic [7:0]        in_base_priority;
  logic [31:0]       in_wake_at;
  logic              out_valid;
  logic              out_ready;
  logic [3:0]        out_chosen_task;
  logic              out_status;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  multilevel_ready_queue_scheduler uut (.*);

  sched_scoreboard sb = new();
  int   words_sent;
  int   words_seen;
  int   burst_left;
  int   ticks_sent;
  bit   hold_req;

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // input and result monitors
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      sb.note(in_kind, in_task_id, in_base_priority, in_wake_at);
      words_seen++;
    end
    if (rst_n && out_valid && out_ready) sb.check(out_chosen_task, out_status);
  end

  // receiver: changing stall pattern, plus one long hold-off on request
  initial begin
    int mode;
    int hold;
    out_ready = 0;
    mode = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 0;
        out_ready <= 0;
        for (hold = 0; hold < 400; hold++) @(posedge clk);
      end
      if ($urandom_range(0, 63) == 0) mode = $urandom_range(0, 2);
      case (mode)
        0: out_ready <= 1;
        1: out_ready <= $urandom_range(0, 1);
        default: out_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  task automatic send_word(logic [2:0] kind, logic [3:0] id, logic [7:0] prio,
                           logic [31:0] wk);
    in_valid <= 1;
    in_kind <= kind;
    in_task_id <= id;
    in_base_priority <= prio;
    in_wake_at <= wk;
    if (kind == K_TICK) ticks_sent++;
    do @(posedge clk); while (!in_ready);
    words_sent++;
    if (burst_left == 0) begin
      burst_left = $urandom_range(0, 12);
      if ($urandom_range(0, 2) != 0) begin
        in_valid <= 0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  task automatic write_threshold(logic [31:0] value);
    psel <= 1;
    pwrite <= 1;
    penable <= 0;
    paddr <= REG_AGING_THR;
    pwdata <= value;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    sb.thr = value[THR_W-1:0];
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
  endtask

  task automatic drain();
    in_valid <= 0;
    while (words_seen != words_sent || sb.picks.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic random_word();
    int r;
    logic [3:0] id;
    logic [31:0] wk;
    logic [7:0] prio;
    r = $urandom_range(0, 99);
    id = 4'($urandom_range(0, SLOTS - 1));
    prio = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, LEVELS - 1));
    case ($urandom_range(0, 9))
      0: wk = $urandom;
      1: wk = 32'hFFFF_FFFF;
      default: wk = ticks_sent + $urandom_range(0, 6);
    endcase
    if (r < 32) send_word(K_TICK, 4'($urandom), 8'($urandom), $urandom);
    else if (r < 52) send_word(K_SLEEP, id, prio, wk);
    else if (r < 78) send_word(K_ADD, id, prio, wk);
    else if (r < 88) send_word(K_REMOVE, id, prio, wk);
    else if (r < 96) send_word(K_EXIT, id, prio, wk);
    else send_word(3'($urandom_range(K_UNKNOWN_FIRST, K_UNKNOWN_LAST)), id, prio, wk);
  endtask

  initial begin
    logic [31:0] thr_list [6];
    rst_n = 0;
    in_valid = 0;
    in_kind = K_TICK;
    in_task_id = 0;
    in_base_priority = 0;
    in_wake_at = 0;
    psel = 0;
    penable = 0;
    pwrite = 0;
    paddr = 0;
    pwdata = 0;
    hold_req = 0;
    words_sent = 0;
    words_seen = 0;
    burst_left = 0;
    ticks_sent = 0;
    sb.clear();
    repeat (8) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: empty scheduler, revive by sleep, clamping, unknown kinds
    send_word(K_TICK, 0, 0, 0);
    send_word(K_ADD, 3, 1, 0);
    send_word(K_SLEEP, 0, 0, 0);
    send_word(K_SLEEP, 15, 8'hFF, 32'd1);
    send_word(K_SLEEP, 7, 0, 32'hFFFF_FFFF);
    send_word(K_TICK, 0, 0, 0);
    send_word(K_ADD, 0, 8'hFF, 0);
    send_word(K_ADD, 15, 0, 32'hFFFF_FFFF);
    send_word(K_ADD, 15, 2, 0);
    send_word(K_TICK, 4'hF, 8'hFF, 32'hFFFF_FFFF);
    send_word(K_REMOVE, 0, 0, 0);
    send_word(K_EXIT, 15, 0, 0);
    send_word(K_TICK, 0, 0, 0);
    send_word(K_ADD, 15, 0, 0);
    send_word(K_UNKNOWN_FIRST, 1, 1, 1);
    send_word(3'd6, 2, 2, 2);
    send_word(K_UNKNOWN_LAST, 3, 3, 3);
    send_word(K_TICK, 0, 0, 0);
    send_word(K_SLEEP, 15, 0, 32'd4);
    send_word(K_TICK, 0, 0, 0);
    send_word(K_TICK, 0, 0, 0);
    send_word(K_TICK, 0, 0, 0);
    send_word(K_TICK, 0, 0, 0);
    drain();

    thr_list = '{32'd1, 32'd65535, 32'd3, 32'd0, 32'($urandom_range(2, 40)), 32'd100};
    foreach (thr_list[p]) begin
      write_threshold(thr_list[p]);
      if (p == 1) hold_req = 1;
      repeat (240) random_word();
      drain();
    end

    if (sb.errors == 0 && sb.picks.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
